// File: rtl/core/zbws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbws_pkg
// Types and constants shared by the z-buffer window point splat block.
// ----------------------------------------------------------------------------
package zbws_pkg;

    localparam int WIN_COLS_DEF  = 1024;
    localparam int WIN_ROWS_DEF  = 256;
    localparam int FRAC_BITS_DEF = 4;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [CFG_W-1:0] WIN_LEFT_RST   = 12'sd200;
    localparam logic signed [CFG_W-1:0] WIN_RIGHT_RST  = 12'sd1200;
    localparam logic signed [CFG_W-1:0] WIN_TOP_RST    = 12'sd80;
    localparam logic signed [CFG_W-1:0] WIN_BOTTOM_RST = 12'sd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_LEFT   = 2'd0,
        CFG_WIN_RIGHT  = 2'd1,
        CFG_WIN_TOP    = 2'd2,
        CFG_WIN_BOTTOM = 2'd3
    } t_cfg_idx;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] u_pos;
        logic signed [15:0] v_pos;
        logic        [23:0] depth_in;
        logic signed [31:0] wx_in;
        logic signed [31:0] wy_in;
        logic signed [31:0] wz_in;
        logic        [9:0]  read_col;
        logic        [7:0]  read_row;
    } t_in_item;

    typedef struct packed {
        logic               inside_res;
        logic               stored;
        logic        [23:0] depth_out;
        logic signed [31:0] wx_out;
        logic signed [31:0] wy_out;
        logic signed [31:0] wz_out;
    } t_out_item;

    typedef struct packed {
        logic [23:0] depth;
        logic [31:0] wx;
        logic [31:0] wy;
        logic [31:0] wz;
    } t_entry;

endpackage

// File: rtl/core/zbuffer_window_point_splat.sv
`timescale 1ns / 1ps
// Each item is accepted in S_IDLE, read from the store in S_ADDR, then modified,
// written back and its result registered in S_MOD, which waits while the output
// stalls; no new item is taken until S_MOD completes (read-modify-write on the
// single store memory). Reset (synchronous, active low) loads the window
// registers with defaults, then zeroes the store, one entry a cycle, over all
// WIN_COLS * WIN_ROWS entries (262144 at defaults); no input is taken meanwhile.
// ----------------------------------------------------------------------------
// zbuffer_window_point_splat
// Nearest-depth z-buffer over a configurable pixel window, with read and clear.
// ----------------------------------------------------------------------------
module zbuffer_window_point_splat
    import zbws_pkg::*;
#(
    parameter int WIN_COLS  = WIN_COLS_DEF,
    parameter int WIN_ROWS  = WIN_ROWS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int DEPTH = WIN_COLS * WIN_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int COLW  = $clog2(WIN_COLS);
    localparam int ROWW  = $clog2(WIN_ROWS);
    localparam int CMPW  = ((CFG_W + FRAC_BITS > 16) ? CFG_W + FRAC_BITS : 16) + 1;
    localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;
    localparam int FRAC_HALF = (1 << FRAC_BITS) >> 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ADDR  = 4'b0100,
        S_MOD   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic signed [CFG_W-1:0] r_win_left, r_win_right, r_win_top, r_win_bottom;

    t_entry         mem [DEPTH];
    t_entry         r_rd_data;
    logic [AW-1:0]  r_clr_addr;
    logic [AW-1:0]  r_addr;
    logic [AW-1:0]  rd_addr;

    t_in_item       r_item;
    logic           r_hit;
    logic [COLW-1:0] r_col;
    logic [ROWW-1:0] r_row;
    logic           n_hit;
    logic [COLW-1:0] n_col;
    logic [ROWW-1:0] n_row;

    logic           r_out_valid;
    t_out_item      r_out_data, n_out_data;

    logic           in_xfer;
    logic           mod_fire;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    t_entry         mem_wdata;
    t_entry         n_entry;
    logic           n_mod_we;

    // window test and rounding
    logic signed [CMPW-1:0] u_ext, v_ext;
    logic signed [CMPW-1:0] left_sc, right_sc, top_sc, bottom_sc;
    logic                   in_win;
    logic signed [15:0]     u_fl, v_fl;
    logic [15:0]            u_frac, v_frac;
    logic                   u_up, v_up;
    logic signed [16:0]     u_rnd, v_rnd;
    logic signed [17:0]     col_s, row_s;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign mod_fire    = (r_state == S_MOD) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        u_ext     = CMPW'(i_in_data.u_pos);
        v_ext     = CMPW'(i_in_data.v_pos);
        left_sc   = CMPW'(r_win_left)   <<< FRAC_BITS;
        right_sc  = CMPW'(r_win_right)  <<< FRAC_BITS;
        top_sc    = CMPW'(r_win_top)    <<< FRAC_BITS;
        bottom_sc = CMPW'(r_win_bottom) <<< FRAC_BITS;
        in_win    = (u_ext > left_sc) && (u_ext < right_sc) &&
                    (v_ext > top_sc) && (v_ext < bottom_sc);

        // round half to even: floor, then bump above half or on an odd half
        u_fl   = i_in_data.u_pos >>> FRAC_BITS;
        v_fl   = i_in_data.v_pos >>> FRAC_BITS;
        u_frac = i_in_data.u_pos & 16'(FRAC_MASK);
        v_frac = i_in_data.v_pos & 16'(FRAC_MASK);
        u_up   = (FRAC_BITS > 0) &&
                 ((u_frac > 16'(FRAC_HALF)) || ((u_frac == 16'(FRAC_HALF)) && u_fl[0]));
        v_up   = (FRAC_BITS > 0) &&
                 ((v_frac > 16'(FRAC_HALF)) || ((v_frac == 16'(FRAC_HALF)) && v_fl[0]));
        u_rnd  = 17'(u_fl) + 17'(u_up);
        v_rnd  = 17'(v_fl) + 17'(v_up);
        col_s  = 18'(u_rnd) - 18'(r_win_left);
        row_s  = 18'(v_rnd) - 18'(r_win_top);

        if (i_in_data.mode == MODE_WRITE) begin
            n_hit = in_win &&
                    !col_s[17] && (col_s[16:0] < 17'(WIN_COLS)) &&
                    !row_s[17] && (row_s[16:0] < 17'(WIN_ROWS));
            n_col = COLW'(col_s);
            n_row = ROWW'(row_s);
        end else begin
            n_hit = (32'(i_in_data.read_col) < 32'(WIN_COLS)) &&
                    (32'(i_in_data.read_row) < 32'(WIN_ROWS));
            n_col = COLW'(i_in_data.read_col);
            n_row = ROWW'(i_in_data.read_row);
        end
    end

    assign rd_addr = AW'(AW'(r_row) * AW'(WIN_COLS)) + AW'(r_col);

    // modify step on the entry read back from the store
    always_comb begin
        n_entry    = r_rd_data;
        n_mod_we   = 1'b0;
        n_out_data = '0;
        if (r_item.mode == MODE_WRITE) begin
            if (r_hit) begin
                n_out_data.inside_res = 1'b1;
                if ((r_item.depth_in != '0) &&
                    ((r_rd_data.depth == '0) || (r_item.depth_in < r_rd_data.depth))) begin
                    n_entry.depth = r_item.depth_in;
                    n_entry.wx    = r_item.wx_in;
                    n_entry.wy    = r_item.wy_in;
                    n_entry.wz    = r_item.wz_in;
                    n_mod_we      = 1'b1;
                    n_out_data.stored = 1'b1;
                end
                n_out_data.depth_out = n_entry.depth;
                n_out_data.wx_out    = n_entry.wx;
                n_out_data.wy_out    = n_entry.wy;
                n_out_data.wz_out    = n_entry.wz;
            end
        end else begin
            if (r_hit) begin
                n_out_data.depth_out = r_rd_data.depth;
                n_out_data.wx_out    = r_rd_data.wx;
                n_out_data.wy_out    = r_rd_data.wy;
                n_out_data.wz_out    = r_rd_data.wz;
                n_entry  = '0;
                n_mod_we = 1'b1;
            end
        end
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = mod_fire && n_mod_we;
            mem_waddr = r_addr;
            mem_wdata = n_entry;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_xfer) n_state = S_ADDR;
            end
            S_ADDR: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (mod_fire) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // store
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADDR) r_rd_data <= mem[rd_addr];
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in_data;
            r_hit  <= n_hit;
            r_col  <= n_col;
            r_row  <= n_row;
        end
        if (r_state == S_ADDR) r_addr <= rd_addr;
        if (mod_fire) r_out_data <= n_out_data;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
            r_win_left   <= WIN_LEFT_RST;
            r_win_right  <= WIN_RIGHT_RST;
            r_win_top    <= WIN_TOP_RST;
            r_win_bottom <= WIN_BOTTOM_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            if (mod_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WIN_LEFT:   r_win_left   <= i_cfg_data;
                    CFG_WIN_RIGHT:  r_win_right  <= i_cfg_data;
                    CFG_WIN_TOP:    r_win_top    <= i_cfg_data;
                    CFG_WIN_BOTTOM: r_win_bottom <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    a_seq_to_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> ##2 (r_state == S_MOD))
        else $error("item did not reach the modify step two cycles after transfer");

    a_stored_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.stored) |->
            (r_out_data.inside_res && (r_out_data.depth_out != '0)))
        else $error("stored result without inside flag or with empty depth");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!r_out_valid && o_in_stall))
        else $error("activity during store clearing pass");

endmodule

// File: verif/zbuffer_window_point_splat_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbuffer_window_point_splat_tb
// Self-checking bench for the windowed z-buffer point splat. A scoreboard keeps
// its own copy of the pixel store and window registers and predicts each
// result. Stimulus covers directed edges, rounding, depth replacement and read
// and clear, then hot-pixel random traffic across several window settings,
// with bursty input and patterned output stalls.
// ----------------------------------------------------------------------------
module zbuffer_window_point_splat_tb;
    import zbws_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int POINTS_PER_PASS = 70;
    localparam int WINDOW_PASSES   = 7;
    localparam int FRAC            = FRAC_BITS_DEF;
    localparam int COLS            = WIN_COLS_DEF;
    localparam int ROWS            = WIN_ROWS_DEF;

    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_HEAVY    = 3;

    class zbuf_scoreboard;
        t_entry    pixel_mem[int];
        t_out_item due_results[$];
        int        win_left;
        int        win_right;
        int        win_top;
        int        win_bottom;
        int        mismatches;
        int        failures;

        function new();
            win_left   = int'(WIN_LEFT_RST);
            win_right  = int'(WIN_RIGHT_RST);
            win_top    = int'(WIN_TOP_RST);
            win_bottom = int'(WIN_BOTTOM_RST);
            mismatches = 0;
            failures   = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            int v;
            v = int'($signed(val));
            case (idx)
                CFG_WIN_LEFT:   win_left   = v;
                CFG_WIN_RIGHT:  win_right  = v;
                CFG_WIN_TOP:    win_top    = v;
                CFG_WIN_BOTTOM: win_bottom = v;
                default: ;
            endcase
        endfunction

        function int round_half_even(logic signed [15:0] x);
            int whole;
            int frac;
            int half;
            whole = int'(x) >>> FRAC;
            if (FRAC == 0) return whole;
            frac = int'(x) & ((1 << FRAC) - 1);
            half = 1 << (FRAC - 1);
            if (frac > half || (frac == half && (whole & 1) != 0)) whole = whole + 1;
            return whole;
        endfunction

        // Apply one transfer to the local store and queue the result it must give.
        function void note_point(t_in_item it);
            t_out_item res;
            t_entry    ent;
            int        u;
            int        v;
            int        col;
            int        row;
            int        addr;
            int        scale;
            res   = '0;
            ent   = '0;
            scale = 1 << FRAC;
            if (it.mode == MODE_WRITE) begin
                u = int'($signed(it.u_pos));
                v = int'($signed(it.v_pos));
                if (u > win_left * scale && u < win_right * scale &&
                    v > win_top * scale && v < win_bottom * scale) begin
                    col = round_half_even(it.u_pos) - win_left;
                    row = round_half_even(it.v_pos) - win_top;
                    if (col >= 0 && col < COLS && row >= 0 && row < ROWS) begin
                        addr = row * COLS + col;
                        if (pixel_mem.exists(addr)) ent = pixel_mem[addr];
                        res.inside_res = 1'b1;
                        if (it.depth_in != 0 && (ent.depth == 0 || it.depth_in < ent.depth)) begin
                            ent.depth = it.depth_in;
                            ent.wx    = it.wx_in;
                            ent.wy    = it.wy_in;
                            ent.wz    = it.wz_in;
                            pixel_mem[addr] = ent;
                            res.stored = 1'b1;
                        end
                    end
                end
            end else if (int'(it.read_col) < COLS && int'(it.read_row) < ROWS) begin
                addr = int'(it.read_row) * COLS + int'(it.read_col);
                if (pixel_mem.exists(addr)) begin
                    ent = pixel_mem[addr];
                    pixel_mem.delete(addr);
                end
            end
            res.depth_out = ent.depth;
            res.wx_out    = ent.wx;
            res.wy_out    = ent.wy;
            res.wz_out    = ent.wz;
            due_results = {due_results, res};
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: %h", $realtime, got);
                return;
            end
            want = due_results.pop_front();
            if (got.inside_res !== want.inside_res || got.stored !== want.stored ||
                got.depth_out !== want.depth_out || got.wx_out !== want.wx_out ||
                got.wy_out !== want.wy_out || got.wz_out !== want.wz_out) begin
                failures++;
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch inside %b/%b stored %b/%b depth %h/%h",
                             $realtime, want.inside_res, got.inside_res, want.stored,
                             got.stored, want.depth_out, got.depth_out);
                    $display("    wx %h/%h wy %h/%h wz %h/%h (expected/actual)",
                             want.wx_out, got.wx_out, want.wy_out, got.wy_out,
                             want.wz_out, got.wz_out);
                end
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    zbuf_scoreboard sb;
    int             cycle_count = 0;
    int             burst_left  = 0;
    int             stall_style = STALL_NONE;
    int             stall_run   = 0;

    zbuffer_window_point_splat dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("zbuffer_window_point_splat_tb: FAIL");
            $finish;
        end
    end

    // Track both channels at the edge, before any new drive lands.
    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (i_in_valid && !o_in_stall) sb.note_point(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        end
    end

    // Output back-pressure: switch between stall styles every so often.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_style <= $urandom_range(STALL_NONE, STALL_HEAVY);
            stall_run   <= $urandom_range(20, 150);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_style)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_RANDOM:   i_out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: i_out_stall <= ((cycle_count % 5) < 2);
            default:        i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Hold the item until its transfer; open a gap between bursts.
    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 24);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_W-1:0];
        @(posedge i_clk);
        sb.set_reg(idx, val[CFG_W-1:0]);
    endtask

    // Drain all pending results, then reprogram the window.
    task automatic set_window(input int l, input int r, input int t, input int b);
        i_in_valid <= 1'b0;
        // let the monitor note the last transfer before polling the queue
        @(posedge i_clk);
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(CFG_WIN_LEFT, l);
        write_reg(CFG_WIN_RIGHT, r);
        write_reg(CFG_WIN_TOP, t);
        write_reg(CFG_WIN_BOTTOM, b);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item make_write(input int u, input int v, input int d,
                                            input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z);
        t_in_item it;
        it          = '0;
        it.mode     = MODE_WRITE;
        it.u_pos    = u[15:0];
        it.v_pos    = v[15:0];
        it.depth_in = d[23:0];
        it.wx_in    = x;
        it.wy_in    = y;
        it.wz_in    = z;
        it.read_col = 10'($urandom);
        it.read_row = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_read(input int col, input int row);
        t_in_item it;
        it          = make_write($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        it.mode     = MODE_READ;
        it.read_col = col[9:0];
        it.read_row = row[7:0];
        return it;
    endfunction

    // Mostly hits on a few hot pixels so depth compares and reads see live entries.
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        int       hc;
        int       hr;
        int       d;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) begin
            hc = $urandom_range(0, 1100);
            hr = $urandom_range(0, 300);
        end else begin
            hc = $urandom_range(0, 5);
            hr = $urandom_range(0, 3);
        end
        case ($urandom_range(0, 9))
            0:       d = 0;
            1:       d = $urandom;
            default: d = $urandom_range(1, 40);
        endcase
        if (pick < 60) begin
            it = make_write((sb.win_left + hc) * 16 + $urandom_range(0, 16) - 8,
                            (sb.win_top + hr) * 16 + $urandom_range(0, 16) - 8,
                            d, $urandom, $urandom, $urandom);
        end else if (pick < 80) begin
            it = make_read(hc, hr);
        end else begin
            it = make_write($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            it.mode = 1'($urandom_range(0, 1));
        end
        return it;
    endfunction

    initial begin
        int u0;
        int v0;
        int l;
        int t;
        int pass;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed checks on the reset window.
        u0 = 200 * 16;
        v0 = 80 * 16;
        send_item(make_read(0, 0));
        send_item(make_write(u0, v0 + 24, 5, 1, 2, 3));
        send_item(make_write(u0 + 1, v0 + 1, 100, 32'h11, 32'h22, 32'h33));
        send_item(make_write(u0 + 1, v0 + 1, 100, 32'h44, 32'h55, 32'h66));
        send_item(make_write(u0 + 7, v0 + 1, 150, 32'h77, 32'h88, 32'h99));
        send_item(make_write(u0 + 1, v0 + 1, 40, 32'hAA, 32'hBB, 32'hCC));
        send_item(make_write(u0 + 1, v0 + 1, 0, 32'hDD, 32'hEE, 32'hFF));
        send_item(make_read(0, 0));
        send_item(make_read(0, 0));
        send_item(make_write(202 * 16 + 8, 90 * 16 + 8, 7, 1, 1, 1));
        send_item(make_write(203 * 16 + 8, 91 * 16 + 8, 9, 2, 2, 2));
        send_item(make_write(u0 + 24, v0 + 40, 1, 3, 3, 3));
        send_item(make_read(2, 10));
        send_item(make_read(4, 12));
        send_item(make_write(1200 * 16 - 1, 300 * 16 - 1, 24'hFFFFFF,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_write(1200 * 16, v0 + 40, 3, 4, 4, 4));
        send_item(make_write(u0 + 40, 300 * 16, 3, 5, 5, 5));
        send_item(make_write(u0 + 40, v0, 3, 6, 6, 6));
        send_item(make_write(-32768, 32767, 3, 7, 7, 7));
        send_item(make_write(32767, -32768, 3, 7, 7, 7));
        send_item(make_read(1000, 220));
        send_item(make_read(1023, 255));

        for (pass = 0; pass < WINDOW_PASSES; pass++) begin
            case (pass)
                1: set_window(-2048, 2047, -2048, 2047);
                2: set_window(10, 30, -5, 12);
                3: set_window(500, 100, 50, 40);
                4: set_window(100, 100, 7, 7);
                5: begin
                    l = $urandom_range(0, 1700) - 200;
                    t = $urandom_range(0, 1700) - 200;
                    set_window(l, l + $urandom_range(1, 1100), t, t + $urandom_range(1, 400));
                end
                6: set_window(2047, -2048, 2047, -2048);
                default: ;
            endcase
            repeat (POINTS_PER_PASS) send_item(random_item());
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.failures == 0 && sb.due_results.size() == 0) begin
            $display("zbuffer_window_point_splat_tb: PASS");
        end else begin
            $display("zbuffer_window_point_splat_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: zbuffer_window_point_splat.f
rtl/core/zbws_pkg.sv
rtl/core/zbuffer_window_point_splat.sv
verif/zbuffer_window_point_splat_tb.sv
